// ===== rtl/core/ara_pkg.sv =====
// shared types and constants for the atlas rectangle allocator
package ara_pkg;

    localparam int ID_W = 16;
    localparam int CS_W = 9;
    localparam int SIDE_W = 10;
    localparam int MINP_W = 10;
    localparam int PAGE_OUT_W = 4;
    localparam int POS_OUT_W = 9;
    localparam int SLOT_OUT_W = 8;
    localparam logic [MINP_W-1:0] MIN_PIECE_RESET = 10'd16;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture request and compute lookup address
        logic hit_check;   // used entry read data valid, decide hit
        logic flush;       // clear counts
        logic scan_rd;     // issue free read at scan index
        logic scan_eval;   // evaluate free entry read data
        logic shift_rd;    // read entry idx for compaction
        logic shift_wr;    // write entry idx-1 from read data
        logic new_page;    // take a fresh page
        logic place;       // write used entry
        logic piece0;      // append first piece
        logic piece1;      // append second piece
        logic done;        // drive result strobe
    } ara_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_hit;
        logic used_full;
        logic scan_end;    // scan index reached free count
        logic fit;         // current entry fits
        logic shift_end;   // compaction reached last entry
        logic pages_full;
    } ara_sts_t;

endpackage

// ===== rtl/core/ara_datapath.sv =====
// datapath: tables, counters and placement arithmetic
module ara_datapath
    import ara_pkg::*;
#(
    parameter int PAGE_SIZE  = 512,
    parameter int MAX_PAGES  = 16,
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ara_cmd_t               cmd,
    output ara_sts_t               sts,
    input  logic [MINP_W-1:0]      min_piece,
    input  logic [ID_W-1:0]        image_id,
    input  logic [CS_W-1:0]        cache_slot,
    input  logic [SIDE_W-1:0]      req_width,
    input  logic [SIDE_W-1:0]      req_height,
    output logic                   hit,
    output logic [PAGE_OUT_W-1:0]  page,
    output logic [POS_OUT_W-1:0]   pos_x,
    output logic [POS_OUT_W-1:0]   pos_y,
    output logic [SLOT_OUT_W-1:0]  slot,
    output logic                   flushed
);
    localparam int CW  = $clog2(PAGE_SIZE + 1);
    localparam int MW  = (CW > MINP_W) ? CW : MINP_W;
    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int FAW = $clog2(FREE_SLOTS);
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int UAW = $clog2(USED_SLOTS);
    localparam int UCW = $clog2(USED_SLOTS + 1);
    localparam int FEW = PW + 4 * CW;
    localparam int UEW = ID_W + PW + 2 * CW;
    localparam int XW  = (CS_W - 1 > UCW) ? CS_W - 1 : UCW;
    localparam logic [CW-1:0] PSZ = CW'(PAGE_SIZE);

    typedef struct packed {
        logic [PW-1:0] pg;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
    } free_ent_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [PW-1:0]   pg;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
    } used_ent_t;

    logic [FEW-1:0] free_mem [FREE_SLOTS];
    logic [UEW-1:0] used_mem [USED_SLOTS];
    logic [FEW-1:0] free_rd_reg;
    logic [UEW-1:0] used_rd_reg;

    logic [FCW-1:0] free_count_reg;
    logic [UCW-1:0] used_count_reg;
    logic [PCW-1:0] page_count_reg;
    logic [FCW-1:0] idx_reg;
    logic           cs_ok_reg;
    logic [UAW-1:0] cs_reg;
    logic [ID_W-1:0] id_reg;
    logic [CW-1:0]  w_reg, h_reg;
    logic [MW-1:0]  mn_reg;
    free_ent_t      f_reg;
    logic           fl_reg;

    free_ent_t fr;
    used_ent_t ur;
    assign fr = free_ent_t'(free_rd_reg);
    assign ur = used_ent_t'(used_rd_reg);

    // clamped request sides
    function automatic logic [CW-1:0] clamp_side(input logic [SIDE_W-1:0] s);
        logic [CW-1:0] r;
        if (s == '0)
            r = CW'(1);
        else if (32'(s) > PAGE_SIZE)
            r = PSZ;
        else
            r = CW'(s);
        return r;
    endfunction

    // lookup validity
    logic [XW-1:0] cs_ext;
    logic [XW-1:0] uc_ext;
    assign cs_ext = XW'(cache_slot[CS_W-2:0]);
    assign uc_ext = XW'(used_count_reg);

    // piece geometry
    logic [CW-1:0] rw, rh;
    logic          wide;
    free_ent_t     p0, p1;
    logic          k0, k1;
    assign rw   = f_reg.w - w_reg;
    assign rh   = f_reg.h - h_reg;
    assign wide = w_reg > h_reg;
    always_comb
    begin
        if (wide)
        begin
            p0 = '{f_reg.pg, f_reg.x + w_reg, f_reg.y, rw, h_reg};
            k0 = (rw >= mn_reg) && (h_reg >= mn_reg);
            p1 = '{f_reg.pg, f_reg.x, f_reg.y + h_reg, f_reg.w, rh};
            k1 = rh >= mn_reg;
        end
        else
        begin
            p0 = '{f_reg.pg, f_reg.x, f_reg.y + h_reg, w_reg, rh};
            k0 = (rh >= mn_reg) && (w_reg >= mn_reg);
            p1 = '{f_reg.pg, f_reg.x + w_reg, f_reg.y, rw, f_reg.h};
            k1 = rw >= mn_reg;
        end
    end

    logic free_has_room;
    assign free_has_room = 32'(free_count_reg) < FREE_SLOTS;

    assign sts.is_hit     = cs_ok_reg && (ur.id == id_reg);
    assign sts.used_full  = 32'(used_count_reg) >= USED_SLOTS;
    assign sts.scan_end   = idx_reg >= free_count_reg;
    assign sts.fit        = (fr.w >= w_reg) && (fr.h >= h_reg);
    assign sts.shift_end  = (idx_reg + FCW'(1)) >= free_count_reg;
    assign sts.pages_full = 32'(page_count_reg) >= MAX_PAGES;

    // memories; during compaction idx points at the entry being moved down
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            used_rd_reg <= used_mem[UAW'(cache_slot[CS_W-2:0])];
        if (cmd.place)
            used_mem[UAW'(used_count_reg)] <= used_ent_t'({id_reg, f_reg.pg, f_reg.x, f_reg.y});
        if (cmd.scan_rd)
            free_rd_reg <= free_mem[idx_reg[FAW-1:0]];
        else if (cmd.shift_rd)
            free_rd_reg <= free_mem[idx_reg[FAW-1:0]];
        if (cmd.shift_wr)
            free_mem[FAW'(idx_reg - FCW'(1))] <= free_rd_reg;
        else if (cmd.piece0 && k0 && free_has_room)
            free_mem[free_count_reg[FAW-1:0]] <= p0;
        else if (cmd.piece1 && k1 && free_has_room)
            free_mem[free_count_reg[FAW-1:0]] <= p1;
    end

    // request capture and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg    <= image_id;
            cs_reg    <= UAW'(cache_slot[CS_W-2:0]);
            cs_ok_reg <= !cache_slot[CS_W-1] && (cs_ext < uc_ext);
            w_reg     <= clamp_side(req_width);
            h_reg     <= clamp_side(req_height);
            mn_reg    <= (min_piece == '0) ? MW'(1) : MW'(min_piece);
        end
        if (cmd.scan_eval && sts.fit)
            f_reg <= fr;
        if (cmd.new_page)
            f_reg <= '{PW'(sts.pages_full ? '0 : page_count_reg), '0, '0, PSZ, PSZ};
    end

    // control counters and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            used_count_reg <= '0;
            page_count_reg <= '0;
            idx_reg        <= '0;
            fl_reg         <= 1'b0;
            hit            <= 1'b0;
            page           <= '0;
            pos_x          <= '0;
            pos_y          <= '0;
            slot           <= '0;
            flushed        <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                fl_reg  <= 1'b0;
            end
            if (cmd.flush)
            begin
                free_count_reg <= '0;
                used_count_reg <= '0;
                page_count_reg <= '0;
                fl_reg         <= 1'b1;
            end
            if (cmd.scan_eval)
                idx_reg <= idx_reg + FCW'(1);
            if (cmd.shift_wr)
                idx_reg <= idx_reg + FCW'(1);
            if (cmd.scan_eval && sts.fit && sts.shift_end)
                free_count_reg <= free_count_reg - FCW'(1);
            if (cmd.shift_wr && sts.shift_end)
                free_count_reg <= free_count_reg - FCW'(1);
            if (cmd.new_page)
            begin
                if (sts.pages_full)
                begin
                    free_count_reg <= '0;
                    used_count_reg <= '0;
                    page_count_reg <= PCW'(1);
                    fl_reg         <= 1'b1;
                end
                else
                    page_count_reg <= page_count_reg + PCW'(1);
            end
            if (cmd.place)
                used_count_reg <= used_count_reg + UCW'(1);
            if ((cmd.piece0 && k0 || cmd.piece1 && k1) && free_has_room)
                free_count_reg <= free_count_reg + FCW'(1);
            if (cmd.done)
            begin
                hit     <= sts.is_hit;
                flushed <= sts.is_hit ? 1'b0 : fl_reg;
                if (sts.is_hit)
                begin
                    page  <= PAGE_OUT_W'(ur.pg);
                    pos_x <= POS_OUT_W'(ur.x);
                    pos_y <= POS_OUT_W'(ur.y);
                    slot  <= SLOT_OUT_W'(cs_reg);
                end
                else
                begin
                    page  <= PAGE_OUT_W'(f_reg.pg);
                    pos_x <= POS_OUT_W'(f_reg.x);
                    pos_y <= POS_OUT_W'(f_reg.y);
                    slot  <= SLOT_OUT_W'(used_count_reg - UCW'(1));
                end
            end
        end
    end

endmodule

// ===== rtl/core/ara_ctrl.sv =====
// controller state machine for the atlas rectangle allocator
module ara_ctrl
    import ara_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output ara_cmd_t cmd,
    input  ara_sts_t sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_CHECK, S_SCAN_RD, S_SCAN_EV, S_SH_RD, S_SH_WR,
        S_NEWPG, S_PLACE, S_PC0, S_PC1, S_DONE, S_HITDONE
    } state_t;

    state_t state_reg;
    logic   hit_d_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:    cmd.load = start;
            S_LOOK:    cmd.hit_check = 1'b1;
            S_CHECK:   cmd.flush = !sts.is_hit && sts.used_full;
            S_SCAN_RD: cmd.scan_rd = !sts.scan_end;
            S_SCAN_EV: cmd.scan_eval = 1'b1;
            S_SH_RD:   cmd.shift_rd = 1'b1;
            S_SH_WR:   cmd.shift_wr = 1'b1;
            S_NEWPG:   cmd.new_page = 1'b1;
            S_PLACE:   cmd.place = 1'b1;
            S_PC0:     cmd.piece0 = 1'b1;
            S_PC1:     cmd.piece1 = 1'b1;
            S_DONE:    cmd.done = 1'b1;
            S_HITDONE: cmd.done = 1'b1;
            default:   cmd = '0;
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = hit_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hit_d_reg <= 1'b0;
        end
        else
        begin
            hit_d_reg <= cmd.done;
            unique case (state_reg)
                S_IDLE:    if (start) state_reg <= S_LOOK;
                S_LOOK:    state_reg <= S_CHECK;
                S_CHECK:   state_reg <= sts.is_hit ? S_HITDONE : S_SCAN_RD;
                S_SCAN_RD: state_reg <= sts.scan_end ? S_NEWPG : S_SCAN_EV;
                S_SCAN_EV:
                begin
                    if (!sts.fit)
                        state_reg <= S_SCAN_RD;
                    else if (sts.shift_end)
                        state_reg <= S_PLACE;
                    else
                        state_reg <= S_SH_RD;
                end
                S_SH_RD:   state_reg <= S_SH_WR;
                S_SH_WR:   state_reg <= sts.shift_end ? S_PLACE : S_SH_RD;
                S_NEWPG:   state_reg <= S_PLACE;
                S_PLACE:   state_reg <= S_PC0;
                S_PC0:     state_reg <= S_PC1;
                S_PC1:     state_reg <= S_DONE;
                S_DONE:    state_reg <= S_IDLE;
                S_HITDONE: state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/atlas_rect_allocator.sv =====
// top level of the atlas rectangle allocator
// A request (start while busy is low) either hits a cached slot or is
// packed first-fit into square pages. A hit passes the lookup, check and
// hit-done states. A miss scans the free list through the single free
// memory read port, reading then evaluating each entry looked at, then
// compacts the list behind the taken entry, reading then writing each
// moved entry, or opens a new page when no free entry fits; it then places
// and appends up to two pieces. Done rises in the same cycle that busy
// falls. Results appear for one cycle with done high and cannot be held
// off. Tables need no clearing after reset.
module atlas_rect_allocator
    import ara_pkg::*;
#(
    parameter int PAGE_SIZE  = 512,
    parameter int MAX_PAGES  = 16,
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output logic                   done,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MINP_W-1:0]      cfg_data,
    input  logic [ID_W-1:0]        image_id,
    input  logic [CS_W-1:0]        cache_slot,
    input  logic [SIDE_W-1:0]      req_width,
    input  logic [SIDE_W-1:0]      req_height,
    output logic                   hit,
    output logic [PAGE_OUT_W-1:0]  page,
    output logic [POS_OUT_W-1:0]   pos_x,
    output logic [POS_OUT_W-1:0]   pos_y,
    output logic [SLOT_OUT_W-1:0]  slot,
    output logic                   flushed
);
    ara_cmd_t cmd;
    ara_sts_t sts;
    logic [MINP_W-1:0] min_piece_reg;

    // config beat always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_piece_reg <= MIN_PIECE_RESET;
        else if (cfg_valid)
            min_piece_reg <= cfg_data;
    end

    ara_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    ara_datapath #(
        .PAGE_SIZE  (PAGE_SIZE),
        .MAX_PAGES  (MAX_PAGES),
        .FREE_SLOTS (FREE_SLOTS),
        .USED_SLOTS (USED_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .min_piece  (min_piece_reg),
        .image_id   (image_id),
        .cache_slot (cache_slot),
        .req_width  (req_width),
        .req_height (req_height),
        .hit        (hit),
        .page       (page),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .slot       (slot),
        .flushed    (flushed)
    );

endmodule

// ===== rtl/core/ara_checker.sv =====
// port-level checks for the atlas rectangle allocator
module ara_checker
    import ara_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic hit,
    input logic flushed
);
    // a request always makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("start not taken");
    // done comes only at the end of busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_done_fall: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("done without request");
    // a hit never reports a flush
    a_hit_flush: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !flushed) else $error("hit with flush");
endmodule

bind atlas_rect_allocator ara_checker u_ara_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .hit     (hit),
    .flushed (flushed)
);
